@@ hdl/vertex_transform_perspective_divide_assert.svh @@
// assertion macros for the vertex transform block
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VTPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vtpd assertion failed");

// antecedent implies consequent in the next cycle
`define VTPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vtpd assertion failed");

`endif

@@ hdl/vtpd_pkg.sv @@
// shared constants and helpers for the vertex transform block
`timescale 1ns / 1ps
package vtpd_pkg;

  localparam int COORD_W   = 32;
  localparam int ENTRY_W   = 16;
  localparam int ROW_W     = 4 * ENTRY_W;
  localparam int PROD_W    = COORD_W + ENTRY_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int FRAC_CUT  = 12;
  localparam int ACC_W     = SUM_W - FRAC_CUT;
  localparam int DIV_STEPS = 32;
  localparam int LANES     = 3;
  localparam int IN_W      = LANES * COORD_W;
  localparam int USER_W    = 2;
  localparam int IDX_W     = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ROW0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW3 = 3'd3;

  // identity matrix at reset
  localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

  localparam logic signed [ACC_W-1:0]   ACC_ONE = ACC_W'(65536);
  localparam logic signed [SUM_W-1:0]   RND_HALF = SUM_W'(2048);
  localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  // signed q4.12 entry of one column
  function automatic logic signed [ENTRY_W-1:0] entry_of(logic [ROW_W-1:0] row,
                                                         logic [1:0] col);
    return $signed(row[col*ENTRY_W +: ENTRY_W]);
  endfunction

endpackage

@@ hdl/vertex_transform_perspective_divide.sv @@
// 4x4 vertex transform with perspective divide, fully pipelined
//
// A point (x, y, z in signed q16.16) enters on the s_axis channel and is
// multiplied as a row vector (with an implicit 1) by the configured matrix
// of signed q4.12 entries. The sums are rounded to q16.16; when w is neither
// 1.0 nor zero, x, y and z are divided by w, truncating toward zero. Results
// are clamped to 32 bits and leave on m_axis, with the flags in tuser.
// A point passes from the input transaction to the output valid through
// one multiply stage, one add and round stage, one divider set-up stage,
// 32 restoring divider stages (one quotient bit each, three lanes side by
// side) and the output register. One point per cycle is taken in steady
// state. When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops; nothing is lost or repeated. Reset clears all valid bits and loads
// the identity matrix. The user must write the matrix through cfg_we_i
// only while the block holds no transaction in flight (not enforced).
`timescale 1ns / 1ps
`include "vertex_transform_perspective_divide_assert.svh"
module vertex_transform_perspective_divide (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vtpd_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [vtpd_pkg::ROW_W-1:0]  cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // point_x, point_y, point_z
  input  logic [vtpd_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // result_x, result_y, result_z
  output logic [vtpd_pkg::IN_W-1:0]   m_axis_tdata,
  // divide_applied, saturated
  output logic [vtpd_pkg::USER_W-1:0] m_axis_tuser
);
  import vtpd_pkg::*;

  logic [ROW_W-1:0] row_q [4];
  logic             adv;

  logic                      v1_q;
  logic signed [PROD_W-1:0]  prod_d [LANES][4];
  logic signed [PROD_W-1:0]  prod_q [LANES][4];
  logic signed [COORD_W-1:0] trans_q [4];

  logic                      v2_q;
  logic signed [ACC_W-1:0]   acc_d [4];
  logic signed [ACC_W-1:0]   acc_q [4];

  logic                      v_q    [DIV_STEPS+1];
  logic                      div_q  [DIV_STEPS+1];
  logic [ACC_W-1:0]          dmag_q [DIV_STEPS+1];
  logic [ACC_W-1:0]          rem_q  [DIV_STEPS+1][LANES];
  logic [ACC_W-1:0]          rem_d  [DIV_STEPS+1][LANES];
  logic [COORD_W-1:0]        low_q  [DIV_STEPS+1][LANES];
  logic [COORD_W-1:0]        quo_q  [DIV_STEPS+1][LANES];
  logic [COORD_W-1:0]        quo_d  [DIV_STEPS+1][LANES];
  logic                      neg_q  [DIV_STEPS+1][LANES];
  logic                      ovf_q  [DIV_STEPS+1][LANES];
  logic signed [ACC_W-1:0]   raw_q  [DIV_STEPS+1][LANES];

  logic                      set_div;
  logic [ACC_W-1:0]          set_dmag;
  logic [ACC_W-1:0]          set_amag [LANES];
  logic                      set_neg  [LANES];
  logic                      set_ovf  [LANES];

  logic                      m_valid_q;
  logic [IN_W-1:0]           m_data_q, m_data_d;
  logic [USER_W-1:0]         m_user_q, m_user_d;

  // matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW0_RST;
      row_q[1] <= ROW1_RST;
      row_q[2] <= ROW2_RST;
      row_q[3] <= ROW3_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW0: row_q[0] <= cfg_data_i;
        REG_ROW1: row_q[1] <= cfg_data_i;
        REG_ROW2: row_q[2] <= cfg_data_i;
        REG_ROW3: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output register is held
  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 1: twelve products
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_d[r][c] = $signed(s_axis_tdata[r*COORD_W +: COORD_W])
                     * entry_of(row_q[r], 2'(c));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      for (int c = 0; c < 4; c++) begin
        trans_q[c] <= {entry_of(row_q[3], 2'(c)), 16'h0000};
      end
    end
  end

  // stage 2: column sums, round half up to q16.16
  always_comb begin
    logic signed [SUM_W-1:0] s;
    for (int c = 0; c < 4; c++) begin
      s = SUM_W'(prod_q[0][c]) + SUM_W'(prod_q[1][c]) + SUM_W'(prod_q[2][c])
        + SUM_W'(trans_q[c]) + RND_HALF;
      acc_d[c] = s[SUM_W-1:FRAC_CUT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      acc_q <= acc_d;
    end
  end

  // stage 3: divider set-up, magnitudes and overflow check
  always_comb begin
    set_div  = (acc_q[3] != ACC_ONE) && (acc_q[3] != '0);
    set_dmag = acc_q[3][ACC_W-1] ? ACC_W'(-acc_q[3]) : ACC_W'(acc_q[3]);
    for (int l = 0; l < LANES; l++) begin
      set_amag[l] = acc_q[l][ACC_W-1] ? ACC_W'(-acc_q[l]) : ACC_W'(acc_q[l]);
      set_neg[l]  = acc_q[l][ACC_W-1] ^ acc_q[3][ACC_W-1];
      // quotient needs more than 32 bits
      set_ovf[l]  = (ACC_W+16)'(set_amag[l]) >= {set_dmag, 16'h0000};
    end
  end

  // divider steps: one quotient bit per stage and lane
  always_comb begin
    logic [ACC_W:0] t;
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        t = {rem_q[k][l], low_q[k][l][COORD_W-1]} - {1'b0, dmag_q[k]};
        if (!t[ACC_W]) begin
          rem_d[k][l] = t[ACC_W-1:0];
          quo_d[k][l] = {quo_q[k][l][COORD_W-2:0], 1'b1};
        end else begin
          rem_d[k][l] = {rem_q[k][l][ACC_W-2:0], low_q[k][l][COORD_W-1]};
          quo_d[k][l] = {quo_q[k][l][COORD_W-2:0], 1'b0};
        end
      end
    end
    for (int l = 0; l < LANES; l++) begin
      rem_d[DIV_STEPS][l] = rem_q[DIV_STEPS][l];
      quo_d[DIV_STEPS][l] = quo_q[DIV_STEPS][l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= v2_q;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0]  <= set_div;
      dmag_q[0] <= set_dmag;
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= set_amag[l] >> 16;
        low_q[0][l] <= {set_amag[l][15:0], 16'h0000};
        quo_q[0][l] <= '0;
        neg_q[0][l] <= set_neg[l];
        ovf_q[0][l] <= set_ovf[l];
        raw_q[0][l] <= acc_q[l];
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
        div_q[k]  <= div_q[k-1];
        dmag_q[k] <= dmag_q[k-1];
        for (int l = 0; l < LANES; l++) begin
          rem_q[k][l] <= rem_d[k-1][l];
          low_q[k][l] <= {low_q[k-1][l][COORD_W-2:0], 1'b0};
          quo_q[k][l] <= quo_d[k-1][l];
          neg_q[k][l] <= neg_q[k-1][l];
          ovf_q[k][l] <= ovf_q[k-1][l];
          raw_q[k][l] <= raw_q[k-1][l];
        end
      end
    end
  end

  // sign, clamp and pack
  always_comb begin
    logic              sat;
    logic [COORD_W-1:0] mag;
    logic signed [ACC_W-1:0] raw;
    sat      = 1'b0;
    m_data_d = '0;
    for (int l = 0; l < LANES; l++) begin
      mag = quo_q[DIV_STEPS][l];
      raw = raw_q[DIV_STEPS][l];
      if (div_q[DIV_STEPS]) begin
        if (ovf_q[DIV_STEPS][l]) begin
          sat = 1'b1;
          m_data_d[l*COORD_W +: COORD_W] = neg_q[DIV_STEPS][l] ? SAT_MIN : SAT_MAX;
        end else if (neg_q[DIV_STEPS][l]) begin
          if (mag > COORD_W'(SAT_MIN)) begin
            sat = 1'b1;
            m_data_d[l*COORD_W +: COORD_W] = SAT_MIN;
          end else begin
            m_data_d[l*COORD_W +: COORD_W] = -mag;
          end
        end else if (mag > COORD_W'(SAT_MAX)) begin
          sat = 1'b1;
          m_data_d[l*COORD_W +: COORD_W] = SAT_MAX;
        end else begin
          m_data_d[l*COORD_W +: COORD_W] = mag;
        end
      end else if (raw > ACC_W'(SAT_MAX)) begin
        sat = 1'b1;
        m_data_d[l*COORD_W +: COORD_W] = SAT_MAX;
      end else if (raw < ACC_W'(SAT_MIN)) begin
        sat = 1'b1;
        m_data_d[l*COORD_W +: COORD_W] = SAT_MIN;
      end else begin
        m_data_d[l*COORD_W +: COORD_W] = raw[COORD_W-1:0];
      end
    end
    m_user_d = {sat, div_q[DIV_STEPS]};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= v_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // checks
  `VTPD_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, v1_q)
  `VTPD_ASSERT_NEXT(a_ovf_saturates, adv && v_q[DIV_STEPS] && div_q[DIV_STEPS] && ovf_q[DIV_STEPS][0], m_axis_tuser[1])
  `VTPD_ASSERT_NEXT(a_nodiv_flag, adv && v_q[DIV_STEPS] && !div_q[DIV_STEPS], !m_axis_tuser[0])
  `VTPD_ASSERT_NOW(a_stall_blocks, m_axis_tvalid && !m_axis_tready, !s_axis_tready && !adv)

endmodule
